>>> design/single_digit_infix_evaluator_unit_assert.svh
// Assertion macros shared by the infix evaluator RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SINGLE_DIGIT_INFIX_EVALUATOR_UNIT_ASSERT_SVH
`define SINGLE_DIGIT_INFIX_EVALUATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sdie_pkg.sv
// Package for the single-digit infix evaluator: widths, character codes,
// operator and error codes, and the request/response types of the shared unit.
// No dependencies.
package sdie_pkg;

  localparam int VALUE_BITS = 8;
  localparam int DIGIT_BITS = 4;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [1:0]            code_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam code_t ALU_ADD = 2'd0;
  localparam code_t ALU_SUB = 2'd1;
  localparam code_t ALU_MUL = 2'd2;
  localparam code_t ALU_DIV = 2'd3;

  localparam code_t SOP_NONE = 2'd0;
  localparam code_t SOP_ADD  = 2'd1;
  localparam code_t SOP_SUB  = 2'd2;

  localparam code_t POP_NONE = 2'd0;
  localparam code_t POP_MUL  = 2'd1;
  localparam code_t POP_DIV  = 2'd2;

  localparam code_t ERR_OK        = 2'd0;
  localparam code_t ERR_SYMBOL    = 2'd1;
  localparam code_t ERR_MALFORMED = 2'd2;
  localparam code_t ERR_DIVZERO   = 2'd3;

  localparam logic [CNT_BITS-1:0] MUL_LAST_STEP = CNT_BITS'(DIGIT_BITS - 1);
  localparam logic [CNT_BITS-1:0] DIV_LAST_STEP = CNT_BITS'(VALUE_BITS - 1);

  typedef struct packed {
    logic   start;
    code_t  op;
    value_t a;
    value_t b;
  } alu_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    value_t result;
  } alu_rsp_t;

endpackage

>>> design/sdie_alu.sv
// Shared iterative arithmetic unit: one-step add/subtract, shift-add multiply
// by a digit and restoring divide by a digit. Depends on sdie_pkg.
module sdie_alu import sdie_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  code_t                 op_r, op_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  value_t                acc_r, acc_nxt;
  value_t                mcand_r, mcand_nxt;
  value_t                quo_r, quo_nxt;
  logic [DIGIT_BITS-1:0] rem_r, rem_nxt;
  logic [DIGIT_BITS-1:0] dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  value_t                res_r, res_nxt;

  value_t                mul_acc;
  logic [DIGIT_BITS:0]   rem_sh;
  logic [DIGIT_BITS:0]   rem_sub;
  logic                  rem_ge;
  value_t                quo_step;

  always_comb begin
    mul_acc  = acc_r + (dvs_r[0] ? mcand_r : '0);
    rem_sh   = {rem_r, quo_r[VALUE_BITS-1]};
    rem_ge   = (rem_sh >= {1'b0, dvs_r});
    rem_sub  = rem_sh - {1'b0, dvs_r};
    quo_step = {quo_r[VALUE_BITS-2:0], rem_ge};
  end

  always_comb begin
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    if (run_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (op_r == ALU_MUL) begin
        acc_nxt   = mul_acc;
        mcand_nxt = {mcand_r[VALUE_BITS-2:0], 1'b0};
        dvs_nxt   = {1'b0, dvs_r[DIGIT_BITS-1:1]};
        if (cnt_r == '0) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = mul_acc;
        end
      end else begin
        quo_nxt = quo_step;
        rem_nxt = rem_ge ? rem_sub[DIGIT_BITS-1:0] : rem_sh[DIGIT_BITS-1:0];
        if (cnt_r == '0) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = neg_r ? (~quo_step + 1'b1) : quo_step;
        end
      end
    end else if (req_i.start) begin
      op_nxt = req_i.op;
      unique case (req_i.op)
        ALU_ADD: begin
          res_nxt  = req_i.a + req_i.b;
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          res_nxt  = req_i.a - req_i.b;
          done_nxt = 1'b1;
        end
        ALU_MUL: begin
          run_nxt   = 1'b1;
          cnt_nxt   = MUL_LAST_STEP;
          acc_nxt   = '0;
          mcand_nxt = req_i.a;
          dvs_nxt   = req_i.b[DIGIT_BITS-1:0];
        end
        ALU_DIV: begin
          run_nxt = 1'b1;
          cnt_nxt = DIV_LAST_STEP;
          neg_nxt = req_i.a[VALUE_BITS-1];
          quo_nxt = req_i.a[VALUE_BITS-1] ? (~req_i.a + 1'b1) : req_i.a;
          rem_nxt = '0;
          dvs_nxt = req_i.b[DIGIT_BITS-1:0];
        end
        default: begin
          done_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    op_r    <= op_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
  end

  assign rsp_o.busy   = run_r;
  assign rsp_o.done   = done_r;
  assign rsp_o.result = res_r;

endmodule

>>> design/single_digit_infix_evaluator_unit.sv
// Top level of the single-digit infix evaluator: stream ports, the expression
// sequencer and its state. Depends on sdie_pkg, sdie_alu and the assert header.
//
// The block takes an expression one ASCII character per request and returns one
// result request for the character marked by in_tlast. A '+' or '-' that follows
// an earlier '+' or '-' first folds that one into the sum. A digit after '*' or '/'
// holds the block while the multiply or divide runs, because the multiply and
// divide run bit by bit in the single shared arithmetic unit. The last character
// holds the block for the final add or subtract and for loading the output
// register. A result that is not yet taken holds the block only when the next
// result is ready to leave.
`include "single_digit_infix_evaluator_unit_assert.svh"

module single_digit_infix_evaluator_unit import sdie_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output value_t     out_tdata,  // [7:0] value
  output code_t      out_tuser   // [1:0] error_code
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_FOLD = 2'd3;

  logic [1:0] state_r, state_nxt;
  value_t     sum_r, sum_nxt;
  code_t      sop_r, sop_nxt;
  value_t     prod_r, prod_nxt;
  code_t      pop_r, pop_nxt;
  logic       expect_r, expect_nxt;
  code_t      err_r, err_nxt;
  logic       last_r, last_nxt;
  logic       dest_r, dest_nxt;
  logic       out_valid_r, out_valid_nxt;
  value_t     out_value_r, out_value_nxt;
  code_t      out_err_r, out_err_nxt;

  value_t     digit;
  logic       out_free;
  alu_req_t   alu_req;
  alu_rsp_t   alu_rsp;

  sdie_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_err_r;
  assign digit      = {{(VALUE_BITS-DIGIT_BITS){1'b0}}, in_tdata[DIGIT_BITS-1:0]};
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    sop_nxt       = sop_r;
    prod_nxt      = prod_r;
    pop_nxt       = pop_r;
    expect_nxt    = expect_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    dest_nxt      = dest_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    alu_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt = in_tlast;
          if (err_r == ERR_OK) begin
            case (in_tdata) inside
              [CH_ZERO:CH_NINE]: begin
                if (!expect_r) begin
                  err_nxt = ERR_MALFORMED;
                end else begin
                  pop_nxt    = POP_NONE;
                  expect_nxt = 1'b0;
                  dest_nxt   = 1'b0;
                  case (pop_r)
                    POP_MUL: begin
                      alu_req = '{start: 1'b1, op: ALU_MUL, a: prod_r, b: digit};
                    end
                    POP_DIV: begin
                      if (digit == '0) begin
                        err_nxt = ERR_DIVZERO;
                      end else begin
                        alu_req = '{start: 1'b1, op: ALU_DIV, a: prod_r, b: digit};
                      end
                    end
                    default: begin
                      prod_nxt = digit;
                    end
                  endcase
                end
              end
              CH_PLUS, CH_MINUS: begin
                if (expect_r) begin
                  err_nxt = ERR_MALFORMED;
                end else begin
                  sop_nxt    = (in_tdata == CH_PLUS) ? SOP_ADD : SOP_SUB;
                  pop_nxt    = POP_NONE;
                  expect_nxt = 1'b1;
                  dest_nxt   = 1'b1;
                  case (sop_r)
                    SOP_ADD: alu_req = '{start: 1'b1, op: ALU_ADD, a: sum_r, b: prod_r};
                    SOP_SUB: alu_req = '{start: 1'b1, op: ALU_SUB, a: sum_r, b: prod_r};
                    default: sum_nxt = prod_r;
                  endcase
                end
              end
              CH_STAR, CH_SLASH: begin
                if (expect_r) begin
                  err_nxt = ERR_MALFORMED;
                end else begin
                  pop_nxt    = (in_tdata == CH_STAR) ? POP_MUL : POP_DIV;
                  expect_nxt = 1'b1;
                end
              end
              default: begin
                err_nxt = ERR_SYMBOL;
              end
            endcase
          end
          if (alu_req.start) begin
            state_nxt = S_CALC;
          end else if (in_tlast) begin
            state_nxt = S_LAST;
          end
        end
      end
      S_CALC: begin
        if (alu_rsp.done) begin
          if (dest_r) begin
            sum_nxt = alu_rsp.result;
          end else begin
            prod_nxt = alu_rsp.result;
          end
          state_nxt = last_r ? S_LAST : S_IDLE;
        end
      end
      S_LAST: begin
        if (err_r == ERR_OK && !expect_r && sop_r != SOP_NONE) begin
          alu_req = '{start: 1'b1, op: (sop_r == SOP_ADD) ? ALU_ADD : ALU_SUB,
                      a: sum_r, b: prod_r};
          state_nxt = S_FOLD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r != ERR_OK || expect_r) begin
            out_value_nxt = '0;
            out_err_nxt   = (err_r != ERR_OK) ? err_r : ERR_MALFORMED;
          end else begin
            out_value_nxt = prod_r;
            out_err_nxt   = ERR_OK;
          end
          sum_nxt    = '0;
          sop_nxt    = SOP_NONE;
          prod_nxt   = '0;
          pop_nxt    = POP_NONE;
          expect_nxt = 1'b1;
          err_nxt    = ERR_OK;
          last_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      S_FOLD: begin
        if (alu_rsp.done) begin
          prod_nxt  = alu_rsp.result;
          sop_nxt   = SOP_NONE;
          state_nxt = S_LAST;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      sop_r       <= SOP_NONE;
      prod_r      <= '0;
      pop_r       <= POP_NONE;
      expect_r    <= 1'b1;
      err_r       <= ERR_OK;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      sop_r       <= sop_nxt;
      prod_r      <= prod_nxt;
      pop_r       <= pop_nxt;
      expect_r    <= expect_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dest_r      <= dest_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  `SDIE_ASSERT_NOW(a_ready_alu_idle, in_tready, !alu_rsp.busy,
    "Input accepted while the shared unit is still running.")
  `SDIE_ASSERT_NEXT(a_calc_leaves, state_r == S_CALC && alu_rsp.done, state_r != S_CALC,
    "Sequencer stayed in the calculate state after the unit finished.")
  `SDIE_ASSERT_NOW(a_error_zero_value, out_tvalid && out_tuser != ERR_OK, out_tdata == '0,
    "An error result carries a nonzero value.")
  `SDIE_ASSERT_NEXT(a_last_blocks, in_tvalid && in_tready && in_tlast, !in_tready,
    "A last character did not hold off the next request.")

endmodule

>>> bench/tb_single_digit_infix_evaluator_unit.sv
// Self-checking testbench for single_digit_infix_evaluator_unit: expressions go in one
// character per request and every result request is checked against an in-bench evaluator.
// Depends on sdie_pkg and the RTL of the block.
module tb_single_digit_infix_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sdie_pkg::*;

  localparam int RANDOM_CHARS = 550;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 30;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       pause;
  } char_req_t;

  typedef struct {
    value_t value;
    code_t  code;
  } eval_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  value_t     out_tdata;
  code_t      out_tuser;

  char_req_t    char_backlog[$];
  eval_result_t exp_values[$];

  value_t sum_acc = '0;
  code_t  sum_op = SOP_NONE;
  value_t prod_acc = '0;
  code_t  prod_op = POP_NONE;
  logic   want_digit = 1'b1;
  code_t  err_now = ERR_OK;

  int chars_sent = 0;
  int quiet_from = 32'h7fff_ffff;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int mismatches = 0;

  single_digit_infix_evaluator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial forever #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic value_t folded_sum();
    if (sum_op == SOP_ADD) return sum_acc + prod_acc;
    if (sum_op == SOP_SUB) return sum_acc - prod_acc;
    return prod_acc;
  endfunction

  function automatic void eval_char(input logic [7:0] ch, input logic last);
    value_t       dig;
    int           num;
    eval_result_t res;
    dig = value_t'(ch - CH_ZERO);
    if (err_now == ERR_OK) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        if (!want_digit) begin
          err_now = ERR_MALFORMED;
        end else begin
          if (prod_op == POP_MUL) begin
            prod_acc = prod_acc * dig;
          end else if (prod_op == POP_DIV) begin
            if (dig == '0) begin
              err_now = ERR_DIVZERO;
            end else begin
              num = $signed(prod_acc);
              prod_acc = value_t'(num / int'(dig));
            end
          end else begin
            prod_acc = dig;
          end
          prod_op = POP_NONE;
          want_digit = 1'b0;
        end
      end else if (ch == CH_PLUS || ch == CH_MINUS) begin
        if (want_digit) begin
          err_now = ERR_MALFORMED;
        end else begin
          sum_acc = folded_sum();
          sum_op = (ch == CH_PLUS) ? SOP_ADD : SOP_SUB;
          prod_op = POP_NONE;
          want_digit = 1'b1;
        end
      end else if (ch == CH_STAR || ch == CH_SLASH) begin
        if (want_digit) begin
          err_now = ERR_MALFORMED;
        end else begin
          prod_op = (ch == CH_STAR) ? POP_MUL : POP_DIV;
          want_digit = 1'b1;
        end
      end else begin
        err_now = ERR_SYMBOL;
      end
    end
    if (last) begin
      if (err_now == ERR_OK && want_digit) err_now = ERR_MALFORMED;
      res.code = err_now;
      res.value = (err_now == ERR_OK) ? folded_sum() : '0;
      exp_values.push_back(res);
      sum_acc = '0;
      sum_op = SOP_NONE;
      prod_acc = '0;
      prod_op = POP_NONE;
      want_digit = 1'b1;
      err_now = ERR_OK;
    end
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic push_expr(input logic [7:0] text[$], input logic pause);
    char_req_t req;
    for (int i = 0; i < text.size(); i++) begin
      req.ch = text[i];
      req.last = (i == text.size() - 1);
      req.pause = pause && (i == 0);
      char_backlog.push_back(req);
    end
  endtask

  task automatic push_text(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    push_expr(text, 1'b0);
  endtask

  task automatic push_random_expr(input logic pause);
    logic [7:0] text[$];
    int terms, kind, pos;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      terms = $urandom_range(1, 6);
      for (int i = 0; i < terms; i++) begin
        if (i > 0) text.push_back(pick_op());
        if (i > 0 && text[$] == CH_SLASH && $urandom_range(0, 3) == 0) begin
          text.push_back(CH_ZERO);
        end else begin
          text.push_back(pick_digit());
        end
      end
      // A well-formed expression is broken in one place for the last few kinds.
      if (kind >= 15) begin
        pos = $urandom_range(0, text.size() - 1);
        case (kind)
          15: text[pos] = 8'($urandom_range(0, 255));
          16: text.insert(pos, pick_digit());
          17: text.insert(pos, pick_op());
          18: text.push_back(pick_op());
          default: text.delete(pos);
        endcase
      end
    end
    if (text.size() == 0) text.push_back(pick_digit());
    push_expr(text, pause);
  endtask

  task automatic note_mismatch(input string why, input value_t want_v, input code_t want_c);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected value %0d code %0d, got value %0d code %0d", $realtime, why,
               $signed(want_v), want_c, $signed(out_tdata), out_tuser);
    end
  endtask

  always @(posedge clk) begin
    char_req_t head;
    logic      taken;
    taken = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (taken) begin
        eval_char(in_tdata, in_tlast);
        chars_sent++;
      end
      if (!in_tvalid || taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (char_backlog.size() != 0 &&
                     !(char_backlog[0].pause && exp_values.size() != 0)) begin
          head = char_backlog.pop_front();
          in_tdata <= head.ch;
          in_tlast <= head.last;
          in_tvalid <= 1'b1;
          if (chars_sent < quiet_from && $urandom_range(0, 9) < 2) begin
            send_gap = $urandom_range(1, 7);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && chars_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (chars_sent < quiet_from && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    eval_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_values.size() == 0) begin
        note_mismatch("unexpected result", '0, ERR_OK);
      end else begin
        want = exp_values.pop_front();
        if (out_tdata !== want.value || out_tuser !== want.code) begin
          note_mismatch("wrong result", want.value, want.code);
        end
      end
    end
  end

  initial begin
    int start, expr_count;
    push_text("9*9*9");
    push_text("7/0");
    push_text("5-8/3+2");
    push_text("+");
    push_text("12");
    push_text("4*");
    push_expr('{"3", 8'hFF}, 1'b0);
    push_expr('{8'h00}, 1'b0);
    push_text("0");
    start = char_backlog.size();
    expr_count = 0;
    while (char_backlog.size() - start < RANDOM_CHARS) begin
      push_random_expr(expr_count == 0 || expr_count == 80);
      expr_count++;
    end
    quiet_from = char_backlog.size() * 85 / 100;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (char_backlog.size() != 0 || in_tvalid) @(posedge clk);
    while (exp_values.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/sdie_pkg.sv
design/sdie_alu.sv
design/single_digit_infix_evaluator_unit.sv
bench/tb_single_digit_infix_evaluator_unit.sv
